@@ hw/rtl/zmtd_pkg.sv @@
// ----------------------------------------------------------------------------
// zmtd_pkg
// Shared types, codes and the alphabet table of the text decoder.
// ----------------------------------------------------------------------------
package zmtd_pkg;

	localparam int QDEPTH = 4;
	localparam int QAW    = 2;

	localparam logic [1:0] KIND_CHAR   = 2'd0;
	localparam logic [1:0] KIND_ABBREV = 2'd1;
	localparam logic [1:0] KIND_END    = 2'd2;
	localparam logic [1:0] KIND_ERROR  = 2'd3;

	localparam logic [1:0] REG_VERSION   = 2'd0;
	localparam logic [1:0] REG_MAX_CHARS = 2'd1;
	localparam logic [1:0] REG_MAX_WORDS = 2'd2;

	localparam logic [3:0]  VERSION_RST   = 4'd3;
	localparam logic [11:0] MAX_CHARS_RST = 12'd2047;
	localparam logic [9:0]  MAX_WORDS_RST = 10'd513;

	localparam logic [7:0] CHAR_SPACE = 8'h20;

	typedef struct packed {
		logic [3:0]  version;
		logic [11:0] max_chars;
		logic [9:0]  max_words;
	} cfg_t;

	typedef struct packed {
		logic        err;
		logic [15:0] word;
	} entry_t;

	typedef struct packed {
		logic [1:0] kind;
		logic       nonempty;
		logic [6:0] abbrev_index;
		logic [7:0] char_code;
	} res_t;

	function automatic logic [7:0] alpha_char(input logic [1:0] a, input logic [4:0] z);
		logic [7:0] c;
		c = 8'h20;
		case (a)
			2'd1: c = 8'h41 + {3'd0, z};
			2'd2: begin
				case (z)
					5'd0:  c = 8'h20;
					5'd1:  c = 8'h0a;
					5'd12: c = 8'h2e;
					5'd13: c = 8'h2c;
					5'd14: c = 8'h21;
					5'd15: c = 8'h3f;
					5'd16: c = 8'h5f;
					5'd17: c = 8'h23;
					5'd18: c = 8'h27;
					5'd19: c = 8'h22;
					5'd20: c = 8'h2f;
					5'd21: c = 8'h5c;
					5'd22: c = 8'h2d;
					5'd23: c = 8'h3a;
					5'd24: c = 8'h28;
					5'd25: c = 8'h29;
					default: c = 8'h30 + {3'd0, z} - 8'd2;
				endcase
			end
			default: c = 8'h61 + {3'd0, z};
		endcase
		return c;
	endfunction

endpackage

@@ hw/rtl/zmtd_front.sv @@
// ----------------------------------------------------------------------------
// zmtd_front
// Accepts text words, counts words per string and tags over-limit words.
// ----------------------------------------------------------------------------
module zmtd_front (
	input  logic              clk,
	input  logic              arst_n,
	input  zmtd_pkg::cfg_t    cfg,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [15:0]       s_tdata,
	input  logic              enq_ready,
	output logic              enq_valid,
	output zmtd_pkg::entry_t  enq_entry
);

	logic [9:0] word_count_q;
	logic       over;

	assign over            = word_count_q >= cfg.max_words;
	assign s_tready        = enq_ready;
	assign enq_valid       = s_tvalid;
	assign enq_entry.err   = over;
	assign enq_entry.word  = s_tdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_count_q <= '0;
		end else if (s_tvalid && enq_ready) begin
			if (over || s_tdata[15]) begin
				word_count_q <= '0;
			end else begin
				word_count_q <= word_count_q + 10'd1;
			end
		end
	end

endmodule

@@ hw/rtl/zmtd_fifo.sv @@
// ----------------------------------------------------------------------------
// zmtd_fifo
// Short queue of tagged words between the front and the back.
// ----------------------------------------------------------------------------
module zmtd_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              enq_valid,
	output logic              enq_ready,
	input  zmtd_pkg::entry_t  enq_entry,
	output logic              deq_valid,
	input  logic              deq_pop,
	output zmtd_pkg::entry_t  deq_entry
);

	zmtd_pkg::entry_t                 mem_q [zmtd_pkg::QDEPTH];
	logic [zmtd_pkg::QAW-1:0]         wr_ptr_q;
	logic [zmtd_pkg::QAW-1:0]         rd_ptr_q;
	logic [zmtd_pkg::QAW:0]           count_q;
	logic                             push;
	logic                             pop;

	assign enq_ready = count_q != (zmtd_pkg::QAW+1)'(zmtd_pkg::QDEPTH);
	assign deq_valid = count_q != '0;
	assign deq_entry = mem_q[rd_ptr_q];
	assign push      = enq_valid && enq_ready;
	assign pop       = deq_pop && deq_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= enq_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ hw/rtl/zmtd_back.sv @@
// ----------------------------------------------------------------------------
// zmtd_back
// Steps through the codes of each queued word and drives the result register.
// ----------------------------------------------------------------------------
module zmtd_back (
	input  logic              clk,
	input  logic              arst_n,
	input  zmtd_pkg::cfg_t    cfg,
	input  logic              deq_valid,
	input  zmtd_pkg::entry_t  deq_entry,
	output logic              deq_pop,
	output logic              m_tvalid,
	input  logic              m_tready,
	output zmtd_pkg::res_t    m_res,
	output logic              m_tlast
);

	logic [1:0]  shift_q;
	logic [1:0]  abbr_q;
	logic [1:0]  escp_q;
	logic [4:0]  esch_q;
	logic [11:0] cc_q;
	logic [1:0]  step_q;

	logic           hold_valid_q;
	zmtd_pkg::res_t hold_q;
	logic           out_valid_q;
	zmtd_pkg::res_t out_q;
	logic           out_last_q;

	logic [4:0]     code;
	logic           r_valid;
	zmtd_pkg::res_t r;
	logic [1:0]     n_shift;
	logic [1:0]     n_abbr;
	logic [1:0]     n_escp;
	logic [4:0]     n_esch;
	logic [11:0]    n_cc;
	logic           char_ok;
	logic [4:0]     z;
	logic           go;
	logic           final_step;
	logic           collide;
	zmtd_pkg::res_t end_res;
	zmtd_pkg::res_t err_res;

	assign m_tvalid = out_valid_q;
	assign m_res    = out_q;
	assign m_tlast  = out_last_q;

	always_comb begin
		case (step_q)
			2'd0:    code = deq_entry.word[14:10];
			2'd1:    code = deq_entry.word[9:5];
			default: code = deq_entry.word[4:0];
		endcase
	end

	assign char_ok = cc_q < cfg.max_chars;
	assign z       = code - 5'd6;

	always_comb begin
		r_valid = 1'b0;
		r       = '0;
		n_shift = shift_q;
		n_abbr  = abbr_q;
		n_escp  = escp_q;
		n_esch  = esch_q;
		n_cc    = cc_q;
		if (abbr_q != 2'd0) begin
			r_valid        = 1'b1;
			r.kind         = zmtd_pkg::KIND_ABBREV;
			r.abbrev_index = {abbr_q - 2'd1, code};
			n_abbr         = 2'd0;
			n_shift        = 2'd0;
		end else if (escp_q == 2'd1) begin
			n_esch = code;
			n_escp = 2'd2;
		end else if (escp_q != 2'd0) begin
			r_valid     = char_ok;
			r.char_code = {esch_q[2:0], code};
			n_escp      = 2'd0;
		end else if (code == 5'd0) begin
			r_valid     = char_ok;
			r.char_code = zmtd_pkg::CHAR_SPACE;
		end else if (code < 5'd6) begin
			if (cfg.version >= 4'd3) begin
				if (code < 5'd4) begin
					n_abbr = code[1:0];
				end else begin
					n_shift = code[1:0] + 2'd1;
				end
			end
		end else begin
			if (shift_q == 2'd2 && z == 5'd0) begin
				n_escp = 2'd1;
			end else begin
				r_valid     = char_ok;
				r.char_code = zmtd_pkg::alpha_char(shift_q == 2'd3 ? 2'd0 : shift_q, z);
			end
			n_shift = 2'd0;
		end
		if (r_valid && r.kind == zmtd_pkg::KIND_CHAR) begin
			n_cc = cc_q + 12'd1;
		end
	end

	always_comb begin
		end_res          = '0;
		end_res.kind     = zmtd_pkg::KIND_END;
		end_res.nonempty = cc_q != 12'd0;
		err_res          = '0;
		err_res.kind     = zmtd_pkg::KIND_ERROR;
	end

	assign go         = deq_valid && (!out_valid_q || m_tready);
	assign final_step = step_q == 2'd2 && !deq_entry.word[15];
	assign collide    = final_step && r_valid && hold_valid_q;
	assign deq_pop    = go && (deq_entry.err || step_q == 2'd3 || (final_step && !collide));

	always_ff @(posedge clk) begin
		if (go) begin
			if (deq_entry.err) begin
				out_q      <= err_res;
				out_last_q <= 1'b1;
			end else if (step_q == 2'd3) begin
				out_q      <= end_res;
				out_last_q <= 1'b1;
			end else if (collide) begin
				out_q      <= hold_q;
				out_last_q <= 1'b0;
			end else if (deq_entry.word[15]) begin
				out_q      <= r;
				out_last_q <= 1'b0;
			end else if (final_step) begin
				out_q      <= r_valid ? r : hold_q;
				out_last_q <= 1'b1;
			end else begin
				out_q      <= hold_q;
				out_last_q <= 1'b0;
			end
			if (!deq_entry.err && step_q != 2'd3 && !collide && !deq_entry.word[15]
				&& !final_step && r_valid) begin
				hold_q <= r;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q      <= '0;
			abbr_q       <= '0;
			escp_q       <= '0;
			esch_q       <= '0;
			cc_q         <= '0;
			step_q       <= '0;
			hold_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else if (go) begin
			if (deq_entry.err || step_q == 2'd3) begin
				shift_q     <= '0;
				abbr_q      <= '0;
				escp_q      <= '0;
				esch_q      <= '0;
				cc_q        <= '0;
				step_q      <= '0;
				out_valid_q <= 1'b1;
			end else if (collide) begin
				hold_valid_q <= 1'b0;
				out_valid_q  <= 1'b1;
			end else begin
				shift_q <= n_shift;
				abbr_q  <= n_abbr;
				escp_q  <= n_escp;
				esch_q  <= n_esch;
				cc_q    <= n_cc;
				if (deq_entry.word[15]) begin
					step_q      <= step_q + 2'd1;
					out_valid_q <= r_valid;
				end else if (final_step) begin
					step_q       <= '0;
					out_valid_q  <= r_valid || hold_valid_q;
					hold_valid_q <= 1'b0;
				end else begin
					step_q <= step_q + 2'd1;
					if (r_valid) begin
						out_valid_q  <= hold_valid_q;
						hold_valid_q <= 1'b1;
					end else begin
						out_valid_q <= 1'b0;
					end
				end
			end
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

@@ hw/rtl/zmachine_text_decoder.sv @@
// ----------------------------------------------------------------------------
// zmachine_text_decoder
// Packed text word decoder: three 5-bit codes per word to characters,
// abbreviation references, string end and word limit error items.
// ----------------------------------------------------------------------------
//  channel  | role      | payload
//  s_*      | words in  | s_tdata[15:0] text_word
//  m_*      | items out | m_tdata char_code, abbrev_index, nonempty; m_tuser kind
//  APB      | registers | 0x0 version, 0x4 max_chars, 0x8 max_words
//
//  The code stepper takes a word's three codes in order, then the string end
//  item if the word ends a string; an over-limit word yields only an error
//  item. It issues one code per cycle while a word is queued and the output is
//  not stalled. A word whose last code result meets a held earlier result
//  first sends the held one. Reset clears all string state; registers return
//  to 3, 2047, 513. A four-entry queue stalls input only when it is full.
module zmachine_text_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [15:0] text_word
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [7:0] char_code, [14:8] abbrev_index, [15] nonempty
	output logic [1:0]  m_tuser,   // [1:0] kind
	output logic        m_tlast
);

	zmtd_pkg::cfg_t   cfg_q;
	logic             enq_valid;
	logic             enq_ready;
	zmtd_pkg::entry_t enq_entry;
	logic             deq_valid;
	logic             deq_pop;
	zmtd_pkg::entry_t deq_entry;
	zmtd_pkg::res_t   res;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.version   <= zmtd_pkg::VERSION_RST;
			cfg_q.max_chars <= zmtd_pkg::MAX_CHARS_RST;
			cfg_q.max_words <= zmtd_pkg::MAX_WORDS_RST;
		end else if (psel && penable && pwrite && pready) begin
			case (paddr[3:2])
				zmtd_pkg::REG_VERSION:   cfg_q.version   <= pwdata[3:0];
				zmtd_pkg::REG_MAX_CHARS: cfg_q.max_chars <= pwdata[11:0];
				zmtd_pkg::REG_MAX_WORDS: cfg_q.max_words <= pwdata[9:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			zmtd_pkg::REG_VERSION:   prdata = {28'd0, cfg_q.version};
			zmtd_pkg::REG_MAX_CHARS: prdata = {20'd0, cfg_q.max_chars};
			zmtd_pkg::REG_MAX_WORDS: prdata = {22'd0, cfg_q.max_words};
			default:                 prdata = '0;
		endcase
	end

	zmtd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.enq_ready (enq_ready),
		.enq_valid (enq_valid),
		.enq_entry (enq_entry)
	);

	zmtd_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.enq_valid (enq_valid),
		.enq_ready (enq_ready),
		.enq_entry (enq_entry),
		.deq_valid (deq_valid),
		.deq_pop   (deq_pop),
		.deq_entry (deq_entry)
	);

	zmtd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.deq_valid (deq_valid),
		.deq_entry (deq_entry),
		.deq_pop   (deq_pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_res     (res),
		.m_tlast   (m_tlast)
	);

	assign m_tdata = {res.nonempty, res.abbrev_index, res.char_code};
	assign m_tuser = res.kind;

`ifndef SYNTHESIS
	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == zmtd_pkg::KIND_END || m_tuser == zmtd_pkg::KIND_ERROR)
		|-> m_tlast)
		else $error("end or error item without tlast");

	a_char_only_in_char: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != zmtd_pkg::KIND_CHAR |-> m_tdata[7:0] == 8'd0)
		else $error("char_code set on non-character item");

	a_abbrev_only_in_abbrev: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != zmtd_pkg::KIND_ABBREV |-> m_tdata[14:8] == 7'd0)
		else $error("abbrev_index set on non-abbreviation item");
`endif

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for zmachine_text_decoder. Text words are streamed in
// from a queue, each accepted word is decoded by a behavioral predictor, and
// every output transfer is checked field by field against the oldest expected
// item. Directed words cover shifts, escapes, abbreviations and string ends;
// random strings run under several register settings and handshake stalls.
// ----------------------------------------------------------------------------
module tb;
	import zmtd_pkg::*;

	localparam int CYCLE_LIMIT   = 200000;
	localparam int SETTLE_CYCLES = 64;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] char_code;
		logic [6:0] abbrev_index;
		logic       nonempty;
		logic       last;
	} text_item_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        psel     = 1'b0;
	logic        penable  = 1'b0;
	logic        pwrite   = 1'b0;
	logic [3:0]  paddr    = 4'd0;
	logic [31:0] pwdata   = 32'd0;
	logic [31:0] prdata;
	logic        pready;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata  = 16'd0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;

	zmachine_text_decoder dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	logic [15:0] word_queue[$];
	text_item_t  expected_items[$];
	int          words_queued      = 0;
	int          words_accepted    = 0;
	int          mismatches        = 0;
	int          cycle_count       = 0;
	int          sender_idle_pct   = 0;
	int          receiver_idle_pct = 0;

	logic [3:0]  cfg_version   = VERSION_RST;
	logic [11:0] cfg_max_chars = MAX_CHARS_RST;
	logic [9:0]  cfg_max_words = MAX_WORDS_RST;

	logic [1:0]  shift_sel   = 2'd0;
	logic [1:0]  abbrev_bank = 2'd0;
	logic [1:0]  esc_phase   = 2'd0;
	logic [4:0]  esc_high    = 5'd0;
	logic [9:0]  words_seen  = 10'd0;
	logic [11:0] chars_kept  = 12'd0;

	initial begin
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	function automatic logic [7:0] alpha_byte(input int a, input int z);
		string row;
		case (a)
			0: row = "abcdefghijklmnopqrstuvwxyz";
			1: row = "ABCDEFGHIJKLMNOPQRSTUVWXYZ";
			default: row = " \n0123456789.,!?_#'\"/\\-:()";
		endcase
		return row[z];
	endfunction

	function automatic void clear_string();
		shift_sel   = 2'd0;
		abbrev_bank = 2'd0;
		esc_phase   = 2'd0;
		esc_high    = 5'd0;
		words_seen  = 10'd0;
		chars_kept  = 12'd0;
	endfunction

	function automatic text_item_t make_item(input logic [1:0] kind, input logic [7:0] ch,
			input logic [6:0] ab, input logic ne);
		text_item_t it;
		it.kind         = kind;
		it.char_code    = ch;
		it.abbrev_index = ab;
		it.nonempty     = ne;
		it.last         = 1'b0;
		return it;
	endfunction

	function automatic void keep_char(input logic [7:0] ch);
		if (chars_kept < cfg_max_chars) begin
			chars_kept = chars_kept + 12'd1;
			expected_items.push_back(make_item(KIND_CHAR, ch, 7'd0, 1'b0));
		end
	endfunction

	function automatic void decode_word(input logic [15:0] w);
		logic [4:0] code;
		int         pos;
		int         n0;
		n0 = expected_items.size();
		if (words_seen >= cfg_max_words) begin
			clear_string();
			expected_items.push_back(make_item(KIND_ERROR, 8'd0, 7'd0, 1'b0));
		end else begin
			words_seen = words_seen + 10'd1;
			for (pos = 10; pos >= 0; pos -= 5) begin
				code = w[pos +: 5];
				if (abbrev_bank != 2'd0) begin
					expected_items.push_back(make_item(KIND_ABBREV, 8'd0,
						{abbrev_bank - 2'd1, code}, 1'b0));
					abbrev_bank = 2'd0;
					shift_sel   = 2'd0;
				end else if (esc_phase == 2'd1) begin
					esc_high  = code;
					esc_phase = 2'd2;
				end else if (esc_phase != 2'd0) begin
					keep_char({esc_high[2:0], code});
					esc_phase = 2'd0;
				end else if (code == 5'd0) begin
					keep_char(CHAR_SPACE);
				end else if (code < 5'd6) begin
					if (cfg_version >= 4'd3) begin
						if (code < 5'd4)
							abbrev_bank = code[1:0];
						else
							shift_sel = (code == 5'd4) ? 2'd1 : 2'd2;
					end
				end else begin
					if (shift_sel == 2'd2 && code == 5'd6)
						esc_phase = 2'd1;
					else
						keep_char(alpha_byte(int'(shift_sel), int'(code) - 6));
					shift_sel = 2'd0;
				end
			end
			if (w[15]) begin
				expected_items.push_back(make_item(KIND_END, 8'd0, 7'd0, chars_kept != 12'd0));
				clear_string();
			end
		end
		if (expected_items.size() > n0)
			expected_items[expected_items.size() - 1].last = 1'b1;
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				decode_word(s_tdata);
				words_accepted <= words_accepted + 1;
			end
			if (!s_tvalid || s_tready) begin
				if (word_queue.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
					s_tdata  <= word_queue.pop_front();
					s_tvalid <= 1'b1;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	task automatic report_mismatch(input string msg);
		mismatches++;
		if (mismatches <= 50)
			$display("mismatch at cycle %0d: %s", cycle_count, msg);
	endtask

	task automatic check_field(input string name, input logic [15:0] got,
			input logic [15:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
	endtask

	always @(posedge clk) begin : monitor
		text_item_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (expected_items.size() == 0) begin
					report_mismatch("output transfer with nothing expected");
				end else begin
					want = expected_items.pop_front();
					check_field("kind", m_tuser, want.kind);
					check_field("char_code", m_tdata[7:0], want.char_code);
					check_field("abbrev_index", m_tdata[14:8], want.abbrev_index);
					check_field("nonempty", m_tdata[15], want.nonempty);
					check_field("last", m_tlast, want.last);
				end
			end
			m_tready <= ($urandom_range(0, 99) >= receiver_idle_pct);
		end
	end

	task automatic apb_write(input logic [1:0] idx, input logic [31:0] val);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			REG_VERSION:   cfg_version   = val[3:0];
			REG_MAX_CHARS: cfg_max_chars = val[11:0];
			REG_MAX_WORDS: cfg_max_words = val[9:0];
			default: ;
		endcase
	endtask

	task automatic set_config(input int v, input int mc, input int mw);
		apb_write(REG_VERSION, v);
		apb_write(REG_MAX_CHARS, mc);
		apb_write(REG_MAX_WORDS, mw);
	endtask

	task automatic push_word(input logic last, input logic [4:0] a, input logic [4:0] b,
			input logic [4:0] c);
		word_queue.push_back({last, a, b, c});
		words_queued++;
	endtask

	function automatic logic [4:0] pick_code();
		logic [4:0] c;
		case ($urandom_range(0, 9))
			0: c = 5'd0;
			1: c = 5'($urandom_range(1, 3));
			2: c = 5'($urandom_range(4, 5));
			3: c = 5'($urandom_range(6, 7));
			default: c = 5'($urandom_range(0, 31));
		endcase
		return c;
	endfunction

	task automatic queue_strings(input int n_items, input int max_len);
		int count;
		int len;
		count = 0;
		while (count < n_items) begin
			if ($urandom_range(0, 9) < 2) begin
				word_queue.push_back(16'($urandom_range(0, 65535)));
				words_queued++;
				count++;
			end else begin
				len = $urandom_range(1, max_len);
				for (int i = 0; i < len; i++) begin
					// occasionally leave the end flag off so strings run together
					push_word((i == len - 1) && ($urandom_range(0, 9) != 0),
						pick_code(), pick_code(), pick_code());
					count++;
				end
			end
		end
	endtask

	task automatic drain_and_settle();
		while (words_accepted != words_queued || expected_items.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		sender_idle_pct   = 21;
		receiver_idle_pct = 74;

		push_word(0, 0, 0, 0);
		push_word(1, 31, 31, 31);
		push_word(1, 6, 7, 8);
		push_word(0, 4, 6, 4);
		push_word(0, 31, 5, 8);
		push_word(0, 5, 7, 5);
		push_word(0, 31, 5, 6);
		push_word(0, 31, 31, 0);
		push_word(0, 5, 6, 0);
		push_word(0, 0, 1, 0);
		push_word(0, 3, 31, 2);
		push_word(1, 17, 4, 5);
		push_word(0, 4, 4, 4);
		push_word(1, 4, 5, 4);
		push_word(1, 0, 5, 6);
		push_word(1, 0, 0, 3);
		push_word(0, 5, 4, 9);
		push_word(1, 4, 0, 6);
		push_word(0, 5, 6, 1);
		push_word(1, 2, 3, 0);
		drain_and_settle();

		set_config(3, 2047, 513);
		queue_strings(90, 6);
		drain_and_settle();

		set_config(1, 0, 1);
		push_word(0, 1, 4, 6);
		push_word(0, 0, 0, 0);
		push_word(1, 5, 6, 7);
		queue_strings(40, 3);
		drain_and_settle();

		sender_idle_pct   = 74;
		receiver_idle_pct = 21;
		set_config(8, 4095, 1023);
		queue_strings(90, 8);
		drain_and_settle();

		set_config(2, 5, 4);
		queue_strings(50, 6);
		drain_and_settle();

		sender_idle_pct   = 0;
		receiver_idle_pct = 0;
		set_config(4, 10, 20);
		queue_strings(100, 24);
		drain_and_settle();

		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

@@ sim.f @@
hw/rtl/zmtd_pkg.sv
hw/rtl/zmtd_front.sv
hw/rtl/zmtd_fifo.sv
hw/rtl/zmtd_back.sv
hw/rtl/zmachine_text_decoder.sv
tb/tb.sv
